/* rtl/aapr_pkg.sv */
// Shared constants and the arctangent table for the axis-angle point rotator.
`timescale 1ns / 1ps
package aapr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POINT_WIDTH_DEF  = 24;
  localparam int TABLE_LEN        = 24;
  localparam int STEP_W           = 5;
  localparam int CFG_W            = 16;
  localparam int IDX_W            = 8;
  localparam int MAT_W            = 32;
  localparam int MAT_FRAC         = 24;
  localparam int CRD_W            = 34;
  localparam int KK_W             = 34;
  localparam int V_W              = 52;

  localparam logic [IDX_W-1:0] REG_AXIS_X = 8'd0;
  localparam logic [IDX_W-1:0] REG_AXIS_Y = 8'd1;
  localparam logic [IDX_W-1:0] REG_AXIS_Z = 8'd2;
  localparam logic [IDX_W-1:0] REG_ANGLE  = 8'd3;

  localparam logic signed [CFG_W-1:0] AXIS_X_RST = 16'sd0;
  localparam logic signed [CFG_W-1:0] AXIS_Y_RST = 16'sd0;
  localparam logic signed [CFG_W-1:0] AXIS_Z_RST = 16'sd16384;
  localparam logic signed [CFG_W-1:0] ANGLE_RST  = 16'sd0;

  localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;

  function automatic logic signed [CRD_W-1:0] atan_val(input logic [STEP_W-1:0] i);
    logic signed [CRD_W-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/axis_angle_point_rotator_unit.sv */
// Top level of the axis-angle point rotator: matrix builder and point pipeline.
`timescale 1ns / 1ps
// Rotates streamed 3D points by a matrix built from a configured axis and angle.
// Input points arrive on the s_ channel, rotated points leave on the m_ channel.
// The cfg_ channel writes axis_x, axis_y, axis_z and angle (index 0 to 3); other
// indexes are accepted and ignored. Each write to one of these registers starts a
// matrix rebuild: an iterative CORDIC runs one step per cycle for min(CORDIC_STEPS,
// 24) steps, then the nine matrix entries follow one at a time through shared
// multipliers, each in ST_MAT_A and then ST_MAT_B. During the rebuild s_tready
// and cfg_ready are low.
// Reset restores the register reset values and runs the same rebuild, giving the
// identity matrix.
// The point path has four register stages: input capture, nine products,
// row sums with rounding, saturation into the output register. An accepted point
// sets v1, v2, v3 and v4 in turn; m_tvalid follows v4. One point is taken every
// cycle unless a rebuild runs. When the receiver stalls, stages fill up bubble by
// bubble and s_tready falls only once every stage is full; nothing is lost or repeated.
module axis_angle_point_rotator_unit #(
  parameter int CORDIC_STEPS = aapr_pkg::CORDIC_STEPS_DEF,
  parameter int POINT_WIDTH  = aapr_pkg::POINT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // px, py, pz from the lowest bit up, zero padded to whole bytes.
  input  logic [((3*POINT_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // rx, ry, rz from the lowest bit up, zero padded to whole bytes.
  output logic [((3*POINT_WIDTH+7)/8)*8-1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [aapr_pkg::IDX_W-1:0] cfg_index,
  input  logic [aapr_pkg::CFG_W-1:0] cfg_data
);

  localparam int PW    = POINT_WIDTH;
  localparam int TW    = ((3*PW+7)/8)*8;
  localparam int MW    = aapr_pkg::MAT_W;
  localparam int PRW   = PW + MW;
  localparam int SW    = PRW + 2;
  localparam int NSTEP = (CORDIC_STEPS < aapr_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : aapr_pkg::TABLE_LEN;
  localparam int CW    = aapr_pkg::CRD_W;
  localparam int VW    = aapr_pkg::V_W;
  localparam int KW    = aapr_pkg::KK_W;

  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (PW-1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef enum logic [2:0] {ST_LOAD, ST_ROT, ST_FIN, ST_MAT_A, ST_MAT_B, ST_IDLE} state_t;

  state_t state;
  logic signed [15:0] axis [0:2];
  logic signed [15:0] angle;
  logic [aapr_pkg::STEP_W-1:0] step;
  logic signed [CW-1:0] cx, cy, cz;
  logic neg;
  logic signed [15:0] sin_q, cos_q;
  logic [1:0] row, col;
  logic signed [KW-1:0] kk;
  logic signed [33:0] sk;
  logic signed [MW-1:0] rmat [0:8];

  logic busy;
  logic cfg_fire;
  logic cfg_known;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == aapr_pkg::REG_AXIS_X) || (cfg_index == aapr_pkg::REG_AXIS_Y)
                  || (cfg_index == aapr_pkg::REG_AXIS_Z) || (cfg_index == aapr_pkg::REG_ANGLE);

  // Angle folding and CORDIC step.
  logic signed [16:0] fold;
  logic fold_neg;
  logic signed [CW-1:0] dx, dy, at;
  logic signed [CW-1:0] xr, yr;
  logic signed [15:0] c_cl, s_cl;

  always_comb begin
    if (angle > 16'sd16384) begin
      fold = 17'(angle) - 17'sd32768;
      fold_neg = 1'b1;
    end else if (angle < -16'sd16384) begin
      fold = 17'(angle) + 17'sd32768;
      fold_neg = 1'b1;
    end else begin
      fold = 17'(angle);
      fold_neg = 1'b0;
    end
    dx = cy >>> step;
    dy = cx >>> step;
    at = aapr_pkg::atan_val(step);
    xr = (cx + CW'(32768)) >>> 16;
    yr = (cy + CW'(32768)) >>> 16;
    if (xr > CW'(16384)) c_cl = 16'sd16384;
    else if (xr < -CW'(16384)) c_cl = -16'sd16384;
    else c_cl = xr[15:0];
    if (yr > CW'(16384)) s_cl = 16'sd16384;
    else if (yr < -CW'(16384)) s_cl = -16'sd16384;
    else s_cl = yr[15:0];
  end

  // Matrix entry operands: K[i][j] and (K*K)[i][j] = a_i*a_j - |a|^2 on the diagonal.
  logic signed [16:0] kij;
  logic signed [15:0] m1a, m1b, m2a, m2b;
  logic diag;
  logic [1:0] o1, o2;
  logic signed [KW-1:0] kk_next;
  logic signed [16:0] omc;
  logic signed [VW-1:0] v;
  logic [3:0] ent;

  always_comb begin
    diag = (row == col);
    o1 = (row == 2'd2) ? 2'd0 : row + 2'd1;
    o2 = (o1 == 2'd2) ? 2'd0 : o1 + 2'd1;
    case ({row, col})
      4'b0001: kij = -17'(axis[2]);
      4'b0010: kij = 17'(axis[1]);
      4'b0100: kij = 17'(axis[2]);
      4'b0110: kij = -17'(axis[0]);
      4'b1000: kij = -17'(axis[1]);
      4'b1001: kij = 17'(axis[0]);
      default: kij = '0;
    endcase
    if (diag) begin
      m1a = axis[o1]; m1b = axis[o1];
      m2a = axis[o2]; m2b = axis[o2];
      kk_next = -(KW'(m1a * m1b) + KW'(m2a * m2b));
    end else begin
      m1a = axis[row]; m1b = axis[col];
      m2a = '0; m2b = '0;
      kk_next = KW'(m1a * m1b) + KW'(m2a * m2b);
    end
    omc = 17'sd16384 - 17'(cos_q);
    v = (VW'(sk) <<< 14) + VW'(omc * kk) + (diag ? (VW'(1) <<< 42) : VW'(0));
    ent = 4'(row) * 4'd3 + 4'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      axis[0] <= aapr_pkg::AXIS_X_RST;
      axis[1] <= aapr_pkg::AXIS_Y_RST;
      axis[2] <= aapr_pkg::AXIS_Z_RST;
      angle <= aapr_pkg::ANGLE_RST;
      step <= '0;
      row <= '0;
      col <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_fire && cfg_known) begin
            state <= ST_LOAD;
            unique case (cfg_index)
              aapr_pkg::REG_AXIS_X: axis[0] <= cfg_data;
              aapr_pkg::REG_AXIS_Y: axis[1] <= cfg_data;
              aapr_pkg::REG_AXIS_Z: axis[2] <= cfg_data;
              default: angle <= cfg_data;
            endcase
          end
        end
        ST_LOAD: begin
          cx <= aapr_pkg::GAIN_Q30;
          cy <= '0;
          cz <= CW'(fold) <<< 16;
          neg <= fold_neg;
          step <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (!cz[CW-1]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
          end
          step <= step + 1'b1;
          if (step == aapr_pkg::STEP_W'(NSTEP - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          cos_q <= neg ? -c_cl : c_cl;
          sin_q <= neg ? -s_cl : s_cl;
          row <= '0;
          col <= '0;
          state <= ST_MAT_A;
        end
        ST_MAT_A: begin
          kk <= kk_next;
          sk <= 34'(17'(sin_q) * kij);
          state <= ST_MAT_B;
        end
        ST_MAT_B: begin
          rmat[ent] <= MW'((v + (VW'(1) <<< 17)) >>> 18);
          if (col == 2'd2) begin
            col <= '0;
            if (row == 2'd2) state <= ST_IDLE;
            else row <= row + 2'd1;
          end else begin
            col <= col + 2'd1;
          end
          if (!(row == 2'd2 && col == 2'd2)) state <= ST_MAT_A;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Point pipeline.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic signed [PW-1:0] p1 [0:2];
  logic signed [PRW-1:0] prod [0:8];
  logic signed [SW-1:0] rsum [0:2];
  logic signed [PW-1:0] res [0:2];
  logic signed [SW-1:0] sum_c [0:2];
  logic signed [PW-1:0] sat_c [0:2];
  logic s_fire;

  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1 && !busy;
  assign s_fire = s_tvalid && s_tready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = ((SW'(prod[3*i]) + SW'(prod[3*i+1]) + SW'(prod[3*i+2])
                  + (SW'(1) <<< (aapr_pkg::MAT_FRAC - 1))) >>> aapr_pkg::MAT_FRAC);
      if (rsum[i] > SAT_HI) sat_c[i] = SAT_HI[PW-1:0];
      else if (rsum[i] < SAT_LO) sat_c[i] = SAT_LO[PW-1:0];
      else sat_c[i] = rsum[i][PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_fire;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
    if (en1) begin
      p1[0] <= s_tdata[PW-1:0];
      p1[1] <= s_tdata[2*PW-1:PW];
      p1[2] <= s_tdata[3*PW-1:2*PW];
    end
    if (en2) begin
      for (int k = 0; k < 9; k++) prod[k] <= PRW'(rmat[k]) * PRW'(p1[k%3]);
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) rsum[i] <= sum_c[i];
    end
    if (en4) begin
      for (int i = 0; i < 3; i++) res[i] <= sat_c[i];
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = TW'({res[2], res[1], res[0]});

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst) busy |-> !s_tready)
    else $error("input accepted during matrix rebuild");
  a_cfg_starts_build: assert property (@(posedge clk) disable iff (rst)
    (cfg_fire && cfg_known) |=> busy)
    else $error("register write did not start a rebuild");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && !m_tready) |=> (v4 && $stable(m_tdata)))
    else $error("stalled result was lost or changed");
  a_no_build_with_items: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAT_B) |-> !s_fire)
    else $error("point entered while matrix entries were written");

endmodule

/* tb/axis_angle_point_rotator_unit_tb.sv */
// Self-checking testbench for the axis-angle point rotator with a built-in matrix predictor.
`timescale 1ns / 1ps
module axis_angle_point_rotator_unit_tb;

  localparam int PW = 24;
  localparam int DW = ((3*PW+7)/8)*8;
  localparam int STEPS = 16;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [PW-1:0] z;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] x;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [aapr_pkg::IDX_W-1:0] cfg_index = '0;
  logic [aapr_pkg::CFG_W-1:0] cfg_data = '0;

  point_t point_q[$];
  point_t rotated_q[$];
  longint rot_mat[9];
  logic signed [aapr_pkg::CFG_W-1:0] axis_x_r, axis_y_r, axis_z_r, angle_r;
  int send_gap = 0;
  int recv_stall = 0;
  bit no_idle = 1'b0;
  int mismatches = 0;
  longint cycles = 0;

  axis_angle_point_rotator_unit #(.CORDIC_STEPS(STEPS), .POINT_WIDTH(PW)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void rebuild_matrix();
    longint k[9];
    longint x, y, z, dx, dy, s, c, omc, kk, v;
    longint a;
    bit flip;
    a = angle_r;
    flip = 1'b0;
    if (a > 16384) begin
      a -= 32768; flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768; flip = 1'b1;
    end
    x = aapr_pkg::GAIN_Q30;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < STEPS && i < aapr_pkg::TABLE_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(aapr_pkg::atan_val(i[aapr_pkg::STEP_W-1:0]));
      end else begin
        x += dx; y -= dy; z += longint'(aapr_pkg::atan_val(i[aapr_pkg::STEP_W-1:0]));
      end
    end
    c = clamp_unit(rnd_shift(x, 16));
    s = clamp_unit(rnd_shift(y, 16));
    if (flip) begin
      c = -c; s = -s;
    end
    k = '{0, -longint'(axis_z_r), longint'(axis_y_r),
          longint'(axis_z_r), 0, -longint'(axis_x_r),
          -longint'(axis_y_r), longint'(axis_x_r), 0};
    omc = 16384 - c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kk = 0;
        for (int n = 0; n < 3; n++) kk += k[i*3+n] * k[n*3+j];
        v = s * k[i*3+j] * 16384 + omc * kk;
        if (i == j) v += longint'(1) << 42;
        rot_mat[i*3+j] = rnd_shift(v, 42 - aapr_pkg::MAT_FRAC);
      end
    end
  endfunction

  function automatic point_t rotate_point(point_t p);
    longint pv[3];
    longint acc, r;
    longint hi, lo;
    logic signed [PW-1:0] res[3];
    point_t o;
    hi = (longint'(1) << (PW - 1)) - 1;
    lo = -hi - 1;
    pv = '{longint'(p.x), longint'(p.y), longint'(p.z)};
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rot_mat[i*3+j] * pv[j];
      r = rnd_shift(acc, aapr_pkg::MAT_FRAC);
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      res[i] = r[PW-1:0];
    end
    o.x = res[0]; o.y = res[1]; o.z = res[2];
    return o;
  endfunction

  // Sender: one item per transaction, a random gap after each.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        rotated_q = {rotated_q, rotate_point(point_t'(s_tdata))};
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (point_q.size() > 0) begin
          s_tdata <= DW'(point_q.pop_front());
          s_tvalid <= 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 7);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transaction against the oldest predicted point.
  always @(posedge clk) begin
    point_t got, want;
    int n;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = point_t'(m_tdata);
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected output point %h", m_tdata);
        end else begin
          want = rotated_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
          end
        end
        n = no_idle ? 0 : $urandom_range(0, 7);
        m_tready <= (n == 0);
        recv_stall <= (n == 0) ? 0 : n - 1;
      end else if (!m_tready) begin
        if (recv_stall == 0) m_tready <= 1'b1;
        else recv_stall <= recv_stall - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [aapr_pkg::IDX_W-1:0] idx,
                           input logic [aapr_pkg::CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      aapr_pkg::REG_AXIS_X: axis_x_r = val;
      aapr_pkg::REG_AXIS_Y: axis_y_r = val;
      aapr_pkg::REG_AXIS_Z: axis_z_r = val;
      aapr_pkg::REG_ANGLE:  angle_r = val;
      default: ;
    endcase
    rebuild_matrix();
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (point_q.size() > 0 || s_tvalid || rotated_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [PW-1:0] rnd_coord();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return PW'($signed($urandom_range(0, 4095)) - 2048);
      default: return PW'($urandom);
    endcase
  endfunction

  task automatic push_point(input logic [PW-1:0] x, y, z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    point_q = {point_q, p};
  endtask

  function automatic logic [aapr_pkg::CFG_W-1:0] rnd_cfg();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'h0000;
      default: return aapr_pkg::CFG_W'($urandom);
    endcase
  endfunction

  initial begin
    axis_x_r = aapr_pkg::AXIS_X_RST;
    axis_y_r = aapr_pkg::AXIS_Y_RST;
    axis_z_r = aapr_pkg::AXIS_Z_RST;
    angle_r = aapr_pkg::ANGLE_RST;
    rebuild_matrix();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Identity after reset, point extremes.
    push_point(24'h7FFFFF, 24'h800000, 24'h000000);
    push_point(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    push_point(24'h000000, 24'h000000, 24'h000000);
    push_point(24'h000001, 24'hFFFFFF, 24'h7FFFFF);
    wait_drained();

    // Angle of minus pi, then a quarter turn about z.
    write_reg(aapr_pkg::REG_ANGLE, 16'h8000);
    push_point(24'h123456, 24'hEDCBA9, 24'h000100);
    push_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    wait_drained();
    write_reg(aapr_pkg::REG_ANGLE, 16'h4000);
    push_point(24'h008000, 24'h000000, 24'h000000);
    push_point(24'h7FFFFF, 24'h800000, 24'h800000);
    wait_drained();
    // Angles just past the fold points and the largest positive angle.
    write_reg(aapr_pkg::REG_ANGLE, 16'h4001);
    push_point(24'h008000, 24'h008000, 24'h008000);
    wait_drained();
    write_reg(aapr_pkg::REG_ANGLE, 16'hBFFF);
    push_point(24'h008000, 24'hFF8000, 24'h008000);
    wait_drained();
    write_reg(aapr_pkg::REG_ANGLE, 16'h7FFF);
    push_point(24'h008000, 24'h008000, 24'hFF8000);
    wait_drained();

    // Oversized axis forces saturation; out-of-range indexes are ignored.
    write_reg(aapr_pkg::REG_AXIS_X, 16'h7FFF);
    write_reg(aapr_pkg::REG_AXIS_Y, 16'h8000);
    write_reg(aapr_pkg::REG_AXIS_Z, 16'h7FFF);
    write_reg(8'd4, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    push_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    push_point(24'h800000, 24'h800000, 24'h800000);
    push_point(24'h400000, 24'hC00000, 24'h000001);
    wait_drained();

    for (int ph = 0; ph < 14; ph++) begin
      if ($urandom_range(0, 3) == 0) write_reg(aapr_pkg::IDX_W'($urandom), rnd_cfg());
      write_reg(aapr_pkg::REG_AXIS_X, rnd_cfg());
      write_reg(aapr_pkg::REG_AXIS_Y, rnd_cfg());
      write_reg(aapr_pkg::REG_AXIS_Z, rnd_cfg());
      write_reg(aapr_pkg::REG_ANGLE, rnd_cfg());
      no_idle = (ph % 4 == 1);
      for (int i = 0; i < 100; i++) push_point(rnd_coord(), rnd_coord(), rnd_coord());
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/aapr_pkg.sv
rtl/axis_angle_point_rotator_unit.sv
tb/axis_angle_point_rotator_unit_tb.sv
